// ===== sv/ccac_pkg.sv =====
// ----------------------------------------------------------------------------
// Character cell alpha compositor package
// Shared item types, codes, controller types and divide-by-255 helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ccac_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int ENTRY_W        = 73;

    localparam logic [1:0] OP_CLEAR   = 2'd0;
    localparam logic [1:0] OP_SIMPLE  = 2'd1;
    localparam logic [1:0] OP_COMPLEX = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    localparam logic [2:0] CFG_LAYER_ALPHA  = 3'd0;
    localparam logic [2:0] CFG_BG_GLYPH     = 3'd1;
    localparam logic [2:0] CFG_BG_COLORS    = 3'd2;
    localparam logic [2:0] CFG_TINT_FORE    = 3'd3;
    localparam logic [2:0] CFG_TINT_BACK    = 3'd4;
    localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd5;
    localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd6;

    localparam logic [7:0]  GLYPH_SPACE  = 8'd32;
    localparam logic [24:0] DIV255_RECIP = 25'd16843010;

    typedef struct packed {
        logic [1:0]         opcode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         glyph;
        logic [31:0]        fore_rgba;
        logic [31:0]        back_rgba;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  cell_glyph;
        logic [31:0] cell_fore;
        logic [31:0] cell_back;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_LOOKUP,
        ST_FETCH,
        ST_QSTEP,
        ST_MULSTEP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic latch;
        logic sweep_en;
        logic ram_rd;
        logic fetch;
        logic step_q;
        logic step_mul;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic op_clear;
        logic in_frame;
        logic sweep_last;
    } status_t;

    // Exact floor(x / 255) for x up to 65279.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

// ===== sv/ccac_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ccac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/ccac_ctrl.sv =====
// ----------------------------------------------------------------------------
// Compositor controller
// Sequences clear sweeps and the lookup, blend and write-back or result steps of an item.
// ----------------------------------------------------------------------------
`default_nettype none

module ccac_ctrl
    import ccac_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire status_t status,
    output logic         busy,
    output cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_CLEAR:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOOKUP:
            begin
                if (status.op_clear)
                begin
                    state_next = ST_CLEAR;
                end
                else if (status.in_frame)
                begin
                    state_next = ST_FETCH;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH:   state_next = ST_QSTEP;
            ST_QSTEP:   state_next = ST_MULSTEP;
            ST_MULSTEP: state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                cmd.latch = start;
            end
            ST_CLEAR:   cmd.sweep_en = 1'b1;
            ST_LOOKUP:  cmd.ram_rd   = status.in_frame && !status.op_clear;
            ST_FETCH:   cmd.fetch    = 1'b1;
            ST_QSTEP:   cmd.step_q   = 1'b1;
            ST_MULSTEP: cmd.step_mul = 1'b1;
            ST_FINISH:  cmd.finish   = 1'b1;
            default:    busy         = 1'b1;
        endcase
    end

    a_finish_returns: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FINISH |=> state_reg == ST_IDLE)
        else $error("finish step not followed by idle");

    a_sweep_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && !status.sweep_last) |=> state_reg == ST_CLEAR)
        else $error("clear sweep left early");

endmodule

`default_nettype wire

// ===== sv/ccac_datapath.sv =====
// ----------------------------------------------------------------------------
// Compositor datapath
// Configuration, cell store, frame check, blend and tint arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module ccac_datapath
    import ccac_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW = (CELLS > 1) ? $clog2(CELLS) : 1
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire in_item_t    item,
    input  wire cmd_t        cmd,
    input  wire logic        cfg_valid,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output status_t          status,
    output out_item_t        result,
    output logic             result_valid
);

    logic [7:0]  layer_alpha_reg;
    logic [7:0]  bg_glyph_reg;
    logic [63:0] bg_colors_reg;
    logic [31:0] tint_reg [2];
    logic [6:0]  fw_reg;
    logic [6:0]  fh_reg;

    in_item_t    item_reg;
    logic [AW-1:0] sweep_reg;
    logic [AW-1:0] sweep_next;
    logic        result_valid_reg;
    logic        result_valid_next;
    out_item_t   result_reg;

    logic [7:0]  cell_glyph_reg;
    logic [31:0] cell_col_reg [2];
    logic [15:0] qn_reg [2];
    logic [7:0]  q_reg [2];
    logic [23:0] pm_reg [2][3];
    logic [15:0] tp1_reg [2][3];
    logic [15:0] tp2_reg [2][3];
    logic [15:0] tp3_reg [2];
    logic [48:0] pr_reg [2][3];
    logic [15:0] m1_reg [2][3];
    logic [15:0] m2_reg [2][3];
    logic [15:0] ma_reg [2];

    logic [15:0] x_u;
    logic [15:0] y_u;
    logic [AW-1:0] cell_addr;
    logic        is_draw;
    logic        is_read;
    logic [31:0] src_col [2];
    logic [31:0] blend_col [2];
    logic [31:0] tint_col [2];
    logic [7:0]  new_glyph;
    logic        ram_we;
    logic [AW-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [ENTRY_W-1:0] ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layer_alpha_reg <= 8'd255;
            bg_glyph_reg    <= GLYPH_SPACE;
            bg_colors_reg   <= '0;
            tint_reg[0]     <= '0;
            tint_reg[1]     <= '0;
            fw_reg          <= 7'd64;
            fh_reg          <= 7'd64;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_LAYER_ALPHA:  layer_alpha_reg <= cfg_data[7:0];
                CFG_BG_GLYPH:     bg_glyph_reg    <= cfg_data[7:0];
                CFG_BG_COLORS:    bg_colors_reg   <= cfg_data;
                CFG_TINT_FORE:    tint_reg[0]     <= cfg_data[31:0];
                CFG_TINT_BACK:    tint_reg[1]     <= cfg_data[31:0];
                CFG_FRAME_WIDTH:  fw_reg          <= cfg_data[6:0];
                CFG_FRAME_HEIGHT: fh_reg          <= cfg_data[6:0];
                default:          fw_reg          <= fw_reg;
            endcase
        end
    end

    assign x_u = item_reg.pos_x;
    assign y_u = item_reg.pos_y;
    assign is_draw = (item_reg.opcode == OP_SIMPLE) || (item_reg.opcode == OP_COMPLEX);
    assign is_read = (item_reg.opcode == OP_READ);
    assign cell_addr = AW'(32'(y_u) * 32'(MAX_WIDTH) + 32'(x_u));

    assign status.op_clear   = (item_reg.opcode == OP_CLEAR);
    assign status.in_frame   = !x_u[15] && !y_u[15]
                               && (x_u < {9'd0, fw_reg}) && (x_u < 16'(MAX_WIDTH))
                               && (y_u < {9'd0, fh_reg}) && (y_u < 16'(MAX_HEIGHT));
    assign status.sweep_last = (sweep_reg == AW'(CELLS - 1));

    assign sweep_next = cmd.latch ? '0 : (cmd.sweep_en ? sweep_reg + 1'b1 : sweep_reg);
    assign result_valid_next = cmd.finish && is_read;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg        <= sweep_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign src_col[0] = item_reg.fore_rgba;
    assign src_col[1] = item_reg.back_rgba;

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= item;
        end
        if (cmd.fetch)
        begin
            if (ram_rdata[ENTRY_W-1])
            begin
                cell_glyph_reg  <= ram_rdata[71:64];
                cell_col_reg[0] <= ram_rdata[63:32];
                cell_col_reg[1] <= ram_rdata[31:0];
            end
            else
            begin
                cell_glyph_reg  <= bg_glyph_reg;
                cell_col_reg[0] <= bg_colors_reg[63:32];
                cell_col_reg[1] <= bg_colors_reg[31:0];
            end
            for (int j = 0; j < 2; j++)
            begin
                qn_reg[j] <= 16'(src_col[j][7:0]) * 16'(layer_alpha_reg);
            end
        end
        if (cmd.step_q)
        begin
            for (int j = 0; j < 2; j++)
            begin
                q_reg[j]   <= div255(qn_reg[j]);
                tp3_reg[j] <= 16'(tint_reg[j][7:0]) * 16'(8'd255 - cell_col_reg[j][7:0]);
                for (int k = 0; k < 3; k++)
                begin
                    pm_reg[j][k]  <= 24'(src_col[j][31-8*k -: 8]) * 24'(qn_reg[j]);
                    tp1_reg[j][k] <= 16'(tint_reg[j][7:0]) * 16'(tint_reg[j][31-8*k -: 8]);
                    tp2_reg[j][k] <= 16'(8'd255 - tint_reg[j][7:0])
                                     * 16'(cell_col_reg[j][31-8*k -: 8]);
                end
            end
        end
        if (cmd.step_mul)
        begin
            for (int j = 0; j < 2; j++)
            begin
                ma_reg[j] <= 16'(q_reg[j]) * 16'(8'd255 - cell_col_reg[j][7:0]);
                for (int k = 0; k < 3; k++)
                begin
                    pr_reg[j][k] <= 49'(pm_reg[j][k]) * 49'(DIV255_RECIP);
                    m1_reg[j][k] <= 16'(src_col[j][31-8*k -: 8]) * 16'(q_reg[j]);
                    m2_reg[j][k] <= 16'(cell_col_reg[j][31-8*k -: 8])
                                    * 16'(8'd255 - q_reg[j]);
                end
            end
        end
        if (result_valid_next)
        begin
            result_reg.cell_glyph <= cell_glyph_reg;
            result_reg.cell_fore  <= tint_col[0];
            result_reg.cell_back  <= tint_col[1];
        end
    end

    always_comb
    begin
        for (int j = 0; j < 2; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (item_reg.opcode == OP_SIMPLE)
                begin
                    blend_col[j][31-8*k -: 8] = div255(pr_reg[j][k][47:32])
                                                + div255(m2_reg[j][k]);
                end
                else
                begin
                    blend_col[j][31-8*k -: 8] = div255(m1_reg[j][k] + m2_reg[j][k]);
                end
                tint_col[j][31-8*k -: 8] = div255(tp1_reg[j][k]) + div255(tp2_reg[j][k]);
            end
            blend_col[j][7:0] = cell_col_reg[j][7:0] + div255(ma_reg[j]);
            tint_col[j][7:0]  = cell_col_reg[j][7:0] + div255(tp3_reg[j]);
            if (tint_reg[j][7:0] == 8'd0)
            begin
                tint_col[j] = cell_col_reg[j];
            end
        end
    end

    assign new_glyph = (item_reg.glyph != GLYPH_SPACE) ? item_reg.glyph : cell_glyph_reg;

    assign ram_we    = cmd.sweep_en || (cmd.finish && is_draw);
    assign ram_waddr = cmd.sweep_en ? sweep_reg : cell_addr;
    assign ram_wdata = cmd.sweep_en ? '0 : {1'b1, new_glyph, blend_col[0], blend_col[1]};

    ccac_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CELLS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.ram_rd),
        .raddr (cell_addr),
        .rdata (ram_rdata)
    );

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> (is_read && $past(cmd.finish)))
        else $error("result strobe without a finished read");

    a_store_write_draw: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && !cmd.sweep_en) |-> (is_draw && status.in_frame))
        else $error("cell write outside a draw in the frame");

endmodule

`default_nettype wire

// ===== sv/character_cell_alpha_compositor_core.sv =====
// ----------------------------------------------------------------------------
// Character cell alpha compositor core
// Frame store of character cells with over-blending draws, clear and tinted read.
// ----------------------------------------------------------------------------
// A draw or read in the frame passes the lookup, fetch, quotient, multiply and
// finish states; a read's result strobe is registered from finish. Out-of-frame
// items return from lookup to idle. A clear sweeps the cell store, one entry a cycle.
// After reset the same sweep runs with busy high.
// Results cannot be stalled; configuration writes are always ready.
`default_nettype none

module character_cell_alpha_compositor_core
    import ccac_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire in_item_t    item,
    output out_item_t        result,
    output logic             result_valid,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    ccac_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .busy   (busy),
        .cmd    (cmd)
    );

    ccac_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

`default_nettype wire
